>>> sv/slm_pkg.sv
// Shared constants and types of the 3x3 strict local maximum detector.
`timescale 1ns / 1ps

package slm_pkg;

    // Default sizes handed to the top level parameters
    localparam int DEF_MAX_COLS    = 64;
    localparam int DEF_MAX_ROWS    = 4096;
    localparam int DEF_VALUE_WIDTH = 32;

    // Depth of the decision queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int ROW_REG_W  = 13;
    localparam int COL_REG_W  = 7;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;

    localparam logic [ROW_REG_W-1:0] ROW_COUNT_RST = 13'd1;
    localparam logic [COL_REG_W-1:0] COL_COUNT_RST = 7'd1;

    // Candidates decided by one pixel at (r,c), in raster order:
    // a = (r-1,c-1), b = (r-1,c), c = (r,c-1), d = (r,c)
    typedef struct packed {
        logic d;
        logic c;
        logic b;
        logic a;
    } t_emit_mask;

    localparam int EMIT_W = 4;

    localparam logic [EMIT_W-1:0] EMIT_A = 4'b0001;
    localparam logic [EMIT_W-1:0] EMIT_B = 4'b0010;
    localparam logic [EMIT_W-1:0] EMIT_C = 4'b0100;
    localparam logic [EMIT_W-1:0] EMIT_D = 4'b1000;

endpackage

>>> sv/slm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module slm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/slm_front.sv
// Front part: pixel intake, frame position, line stores, window and peak decisions.
`timescale 1ns / 1ps

module slm_front #(
    parameter int MAX_COLS    = slm_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS    = slm_pkg::DEF_MAX_ROWS,
    parameter int VALUE_WIDTH = slm_pkg::DEF_VALUE_WIDTH,
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int COL_CNT_W = $clog2(MAX_COLS + 1),
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1),
    localparam int JOB_W     = slm_pkg::EMIT_W + ROW_W + COL_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [slm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [slm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_pix_valid,
    output logic                          o_pix_ready,
    input  logic [VALUE_WIDTH-1:0]        i_pix_value,
    output logic                          o_job_push,
    input  logic                          i_job_ready,
    output logic [JOB_W-1:0]              o_job_data
);

    localparam int LINE_W = 2 * VALUE_WIDTH;

    typedef logic signed [VALUE_WIDTH-1:0] t_win [3][3];

    // Frame position and geometry
    logic [ROW_W-1:0]              r_row;
    logic [COL_W-1:0]              r_col;
    logic [slm_pkg::ROW_REG_W-1:0] r_row_count;
    logic [slm_pkg::COL_REG_W-1:0] r_col_count;
    logic [ROW_CNT_W-1:0]          w_nrows;
    logic [COL_CNT_W-1:0]          w_ncols;
    logic                          w_last_col;
    logic                          w_last_row;
    logic                          w_accept;

    // Decision stage
    logic                          r_s1_valid;
    logic signed [VALUE_WIDTH-1:0] r_s1_pix;
    logic [ROW_W-1:0]              r_s1_row;
    logic [COL_W-1:0]              r_s1_col;
    logic                          r_s1_r_ge1;
    logic                          r_s1_r_ge2;
    logic                          r_s1_c_ge1;
    logic                          r_s1_c_ge2;
    logic                          r_s1_last_row;
    logic                          r_s1_last_col;
    logic                          w_fire;

    // Line store data and bypass of a write to the address just read
    logic [LINE_W-1:0]             w_rdata;
    logic [LINE_W-1:0]             w_line;
    logic [LINE_W-1:0]             w_wdata;
    logic                          r_fwd_valid;
    logic [LINE_W-1:0]             r_fwd_data;

    t_win                          r_win;
    t_win                          w_win;
    slm_pkg::t_emit_mask           w_mask;

    function automatic logic f_peak(
        input t_win w,
        input int   wr,
        input int   wc,
        input logic up,
        input logic dn,
        input logic lf,
        input logic rt
    );
        logic ok;
        logic there;
        int   ar;
        int   ac;
        ok = 1'b1;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                ar = wr + dr;
                ac = wc + dc;
                there = !(dr == 0 && dc == 0) &&
                        (ar >= 0) && (ar <= 2) && (ac >= 0) && (ac <= 2) &&
                        (dr != -1 || up) && (dr != 1 || dn) &&
                        (dc != -1 || lf) && (dc != 1 || rt);
                if (there && !(w[wr][wc] > w[ar][ac])) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

    // Zero acts as one, oversize clamps to the maximum
    always_comb begin
        if (r_row_count == '0) begin
            w_nrows = ROW_CNT_W'(1);
        end else if (r_row_count > MAX_ROWS) begin
            w_nrows = ROW_CNT_W'(MAX_ROWS);
        end else begin
            w_nrows = ROW_CNT_W'(r_row_count);
        end
        if (r_col_count == '0) begin
            w_ncols = COL_CNT_W'(1);
        end else if (r_col_count > MAX_COLS) begin
            w_ncols = COL_CNT_W'(MAX_COLS);
        end else begin
            w_ncols = COL_CNT_W'(r_col_count);
        end
    end

    assign w_last_col  = (COL_CNT_W'(r_col) + COL_CNT_W'(1)) == w_ncols;
    assign w_last_row  = (ROW_CNT_W'(r_row) + ROW_CNT_W'(1)) == w_nrows;
    assign w_fire      = r_s1_valid && i_job_ready;
    assign o_pix_ready = !r_s1_valid || w_fire;
    assign w_accept    = i_pix_valid && o_pix_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_row_count <= slm_pkg::ROW_COUNT_RST;
            r_col_count <= slm_pkg::COL_COUNT_RST;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    slm_pkg::CFG_ROW_COUNT: begin
                        r_row_count <= i_cfg_data[slm_pkg::ROW_REG_W-1:0];
                        r_row       <= '0;
                        r_col       <= '0;
                    end
                    slm_pkg::CFG_COL_COUNT: begin
                        r_col_count <= i_cfg_data[slm_pkg::COL_REG_W-1:0];
                        r_row       <= '0;
                        r_col       <= '0;
                    end
                    default: ;
                endcase
            end else if (w_accept) begin
                if (w_last_col) begin
                    r_col <= '0;
                    r_row <= w_last_row ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            r_s1_valid <= w_accept || (r_s1_valid && !w_fire);
            // Hold the bypass choice for as long as the word waits in the stage
            if (w_accept) begin
                r_fwd_valid <= w_fire && (r_s1_col == r_col);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pix      <= i_pix_value;
            r_s1_row      <= r_row;
            r_s1_col      <= r_col;
            r_s1_r_ge1    <= r_row != '0;
            r_s1_r_ge2    <= r_row > ROW_W'(1);
            r_s1_c_ge1    <= r_col != '0;
            r_s1_c_ge2    <= r_col > COL_W'(1);
            r_s1_last_row <= w_last_row;
            r_s1_last_col <= w_last_col;
            r_fwd_data    <= w_wdata;
        end
        if (w_fire) begin
            r_win <= w_win;
        end
    end

    // Each entry holds {row r-2, row r-1} at its column
    slm_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_fire),
        .i_waddr (r_s1_col),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (r_col),
        .o_rdata (w_rdata)
    );

    assign w_line  = r_fwd_valid ? r_fwd_data : w_rdata;
    assign w_wdata = {w_line[VALUE_WIDTH-1:0], r_s1_pix};

    // Shift the window left and bring in the new column
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_win[i][0] = r_win[i][1];
            w_win[i][1] = r_win[i][2];
        end
        w_win[0][2] = w_line[LINE_W-1:VALUE_WIDTH];
        w_win[1][2] = w_line[VALUE_WIDTH-1:0];
        w_win[2][2] = r_s1_pix;
    end

    always_comb begin
        w_mask.a = r_s1_r_ge1 && r_s1_c_ge1 &&
                   f_peak(w_win, 1, 1, r_s1_r_ge2, 1'b1, r_s1_c_ge2, 1'b1);
        w_mask.b = r_s1_r_ge1 && r_s1_last_col &&
                   f_peak(w_win, 1, 2, r_s1_r_ge2, 1'b1, r_s1_c_ge1, 1'b0);
        w_mask.c = r_s1_last_row && r_s1_c_ge1 &&
                   f_peak(w_win, 2, 1, r_s1_r_ge1, 1'b0, r_s1_c_ge2, 1'b1);
        w_mask.d = r_s1_last_row && r_s1_last_col &&
                   f_peak(w_win, 2, 2, r_s1_r_ge1, 1'b0, r_s1_c_ge1, 1'b0);
    end

    // Drop pixels that decide no maximum
    assign o_job_push = w_fire && (w_mask != '0);
    assign o_job_data = {w_mask, r_s1_row, r_s1_col};

endmodule

>>> sv/slm_queue.sv
// Short FIFO of decision words between the front and the back.
`timescale 1ns / 1ps

module slm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = slm_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_in_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_out_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_in_ready  = r_count != CNT_W'(DEPTH);
    assign o_out_valid = r_count != '0;
    assign o_data      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

>>> sv/slm_back.sv
// Back part: expands each decision word into coordinate words, one per cycle while the output is ready.
`timescale 1ns / 1ps

module slm_back #(
    parameter int MAX_COLS = slm_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = slm_pkg::DEF_MAX_ROWS,
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int JOB_W = slm_pkg::EMIT_W + ROW_W + COL_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    output logic             o_job_pop,
    input  logic [JOB_W-1:0] i_job_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [ROW_W-1:0] o_out_row,
    output logic [COL_W-1:0] o_out_col,
    output logic             o_out_last
);

    logic                       r_job_valid;
    slm_pkg::t_emit_mask        r_job_mask;
    logic [ROW_W-1:0]           r_job_row;
    logic [COL_W-1:0]           r_job_col;
    logic [slm_pkg::EMIT_W-1:0] w_bits;
    logic [slm_pkg::EMIT_W-1:0] w_sel;
    logic [slm_pkg::EMIT_W-1:0] w_rem;
    logic [ROW_W-1:0]           w_row;
    logic [COL_W-1:0]           w_col;
    logic                       w_out_free;
    logic                       w_take;
    logic                       w_done;

    logic                       r_out_valid;
    logic [ROW_W-1:0]           r_out_row;
    logic [COL_W-1:0]           r_out_col;
    logic                       r_out_last;

    assign w_bits = r_job_mask;

    // Lowest pending candidate goes first: that is raster order
    always_comb begin
        if (w_bits[0]) begin
            w_sel = slm_pkg::EMIT_A;
        end else if (w_bits[1]) begin
            w_sel = slm_pkg::EMIT_B;
        end else if (w_bits[2]) begin
            w_sel = slm_pkg::EMIT_C;
        end else begin
            w_sel = slm_pkg::EMIT_D;
        end
    end

    always_comb begin
        unique case (w_sel)
            slm_pkg::EMIT_A: begin
                w_row = r_job_row - ROW_W'(1);
                w_col = r_job_col - COL_W'(1);
            end
            slm_pkg::EMIT_B: begin
                w_row = r_job_row - ROW_W'(1);
                w_col = r_job_col;
            end
            slm_pkg::EMIT_C: begin
                w_row = r_job_row;
                w_col = r_job_col - COL_W'(1);
            end
            default: begin
                w_row = r_job_row;
                w_col = r_job_col;
            end
        endcase
    end

    assign w_rem      = w_bits & ~w_sel;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_take     = r_job_valid && w_out_free;
    assign w_done     = w_take && (w_rem == '0);
    assign o_job_pop  = i_job_valid && (!r_job_valid || w_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_job_pop) begin
                r_job_valid <= 1'b1;
            end else if (w_done) begin
                r_job_valid <= 1'b0;
            end
            if (w_out_free) begin
                r_out_valid <= w_take;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job_mask <= i_job_data[JOB_W-1:ROW_W+COL_W];
            r_job_row  <= i_job_data[ROW_W+COL_W-1:COL_W];
            r_job_col  <= i_job_data[COL_W-1:0];
        end else if (w_take) begin
            r_job_mask <= w_rem;
        end
        if (w_take) begin
            r_out_row  <= w_row;
            r_out_col  <= w_col;
            r_out_last <= w_rem == '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_last  = r_out_last;

endmodule

>>> sv/strict_local_maximum_3x3_core.sv
// Path: an accepted pixel word passes the decision stage, the decision queue and the
//   back's job and output registers before its first coordinate word shows on m_axis.
// Throughput: one pixel word per cycle while the 4-entry decision queue has room; the
//   output side moves one coordinate word per cycle while m_axis_tready is high.
// Reset: i_rst_n is synchronous, active low; it restarts the frame at (0,0), sets
//   both counts to 1 and empties the pipeline. The line stores are not cleared.
`timescale 1ns / 1ps

module strict_local_maximum_3x3_core #(
    parameter int MAX_COLS    = slm_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS    = slm_pkg::DEF_MAX_ROWS,
    parameter int VALUE_WIDTH = slm_pkg::DEF_VALUE_WIDTH,
    localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((ROW_W + COL_W + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [slm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [IN_TDATA_W-1:0]          s_axis_tdata,  // pixel_value
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [OUT_TDATA_W-1:0]         m_axis_tdata,  // max_col in the upper bits, max_row in the lower
    output logic                           m_axis_tlast
);

    localparam int JOB_W = slm_pkg::EMIT_W + ROW_W + COL_W;

    logic             w_job_push;
    logic             w_job_in_ready;
    logic [JOB_W-1:0] w_job_in;
    logic             w_job_valid;
    logic             w_job_pop;
    logic [JOB_W-1:0] w_job_out;
    logic [ROW_W-1:0] w_out_row;
    logic [COL_W-1:0] w_out_col;

    slm_front #(
        .MAX_COLS    (MAX_COLS),
        .MAX_ROWS    (MAX_ROWS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix_valid (s_axis_tvalid),
        .o_pix_ready (s_axis_tready),
        .i_pix_value (s_axis_tdata[VALUE_WIDTH-1:0]),
        .o_job_push  (w_job_push),
        .i_job_ready (w_job_in_ready),
        .o_job_data  (w_job_in)
    );

    slm_queue #(
        .WIDTH (JOB_W),
        .DEPTH (slm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_job_push),
        .o_in_ready  (w_job_in_ready),
        .i_data      (w_job_in),
        .o_out_valid (w_job_valid),
        .i_pop       (w_job_pop),
        .o_data      (w_job_out)
    );

    slm_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .o_job_pop   (w_job_pop),
        .i_job_data  (w_job_out),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_row   (w_out_row),
        .o_out_col   (w_out_col),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TDATA_W'({w_out_col, w_out_row});

endmodule

>>> sv/slm_checker.sv
// Port-level checks of the 3x3 strict local maximum core, bound to the top level.
`timescale 1ns / 1ps

module slm_checker #(
    parameter int OUT_TDATA_W = 24
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    // Reset empties the pipeline and opens the input
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (s_axis_tready && !m_axis_tvalid))
        else $error("core not idle after reset");

    // Words of one pixel leave back to back
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("gap inside a run of result words");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result word changed");

    // A pixel word offered on the first cycle out of reset is accepted
    a_first_accept: assert property (@(posedge i_clk)
        ($past(!i_rst_n) && i_rst_n && s_axis_tvalid) |-> s_axis_tready)
        else $error("input refused right after reset");

endmodule

bind strict_local_maximum_3x3_core slm_checker #(
    .OUT_TDATA_W (OUT_TDATA_W)
) u_slm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
